/* sv/rmwq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rmwq_pkg;

    // Sizes of the queue and of the task map
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_TASKS   = 256;

    localparam int TASK_W  = 8;
    localparam int NEST_W  = 8;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MAP_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [NEST_W-1:0] NEST_MAX = '1;

    typedef enum logic [0:0] {
        KIND_ACQUIRE = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_GRANTED        = 3'd0,
        ST_NESTED_GRANT   = 3'd1,
        ST_BLOCKED        = 3'd2,
        ST_RELEASED       = 3'd3,
        ST_NESTED_RELEASE = 3'd4,
        ST_NOT_HOLDER     = 3'd5,
        ST_QUEUE_ERR      = 3'd6,
        ST_OVERFLOW       = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    // Write port of the wait queue memory
    typedef struct packed {
        logic              en;
        logic [QPTR_W-1:0] addr;
        logic [TASK_W-1:0] data;
    } fifo_wr_t;

    // Read port of the wait queue memory
    typedef struct packed {
        logic              en;
        logic [QPTR_W-1:0] addr;
    } fifo_rd_t;

endpackage

`default_nettype wire

/* sv/rmwq_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rmwq_req_if
    import rmwq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output kind, output task_id, input ready);
    modport sink   (input valid, input kind, input task_id, output ready);
endinterface

`default_nettype wire

/* sv/rmwq_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rmwq_rsp_if
    import rmwq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
    logic [NEST_W-1:0] nest_level;

    modport source (output valid, output status, output woken_valid, output woken_task,
                    output nest_level, input ready);
    modport sink   (input valid, input status, input woken_valid, input woken_task,
                    input nest_level, output ready);
endinterface

`default_nettype wire

/* sv/rmwq_fifo_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmwq_fifo_mem
    import rmwq_pkg::*;
(
    input  wire logic              clk,
    input  wire fifo_wr_t          wr,
    input  wire fifo_rd_t          rd,
    output logic [TASK_W-1:0]      rd_data
);

    logic [TASK_W-1:0] mem [QUEUE_DEPTH];
    logic [TASK_W-1:0] rd_data_reg;

    // Write one waiter id
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read of the head entry
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/rmwq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmwq_ctrl
    import rmwq_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    rmwq_req_if.sink           req,
    rmwq_rsp_if.source         rsp,
    output fifo_wr_t           fifo_wr,
    output fifo_rd_t           fifo_rd,
    input  wire logic [TASK_W-1:0] fifo_rd_data
);

    localparam logic [QPTR_W-1:0] PTR_LAST  = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL  = QCNT_W'(QUEUE_DEPTH);
    localparam logic [TASK_W:0]   TASK_LIMIT = (TASK_W + 1)'(NUM_TASKS);
    localparam logic [MAP_W-1:0]  CLR_LAST  = MAP_W'(NUM_TASKS - 1);

    state_t state_reg, state_next;

    // Latched request
    logic              kind_reg;
    logic [TASK_W-1:0] tid_reg;

    // Lock and queue bookkeeping
    logic              holder_valid_reg, holder_valid_next;
    logic [TASK_W-1:0] holder_task_reg, holder_task_next;
    logic [NEST_W-1:0] nest_reg, nest_next;
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] used_reg, used_next;

    // Per-task waiting map memory and its clearing pass
    logic              wait_map [NUM_TASKS];
    logic              map_hit_reg;
    logic [MAP_W-1:0]  clr_reg, clr_next;
    logic              clearing;
    logic              map_rd_en;
    logic              map_wr_en;
    logic [MAP_W-1:0]  map_wr_addr;
    logic              map_wr_data;

    // Response register
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic              out_wv_reg, out_wv_next;
    logic [TASK_W-1:0] out_wt_reg, out_wt_next;
    logic [NEST_W-1:0] out_nest_reg, out_nest_next;

    logic take;
    logic exec_go;
    logic is_holder;
    logic tid_in_map;
    logic wt_in_map;
    logic [MAP_W-1:0] tid_idx;
    logic [MAP_W-1:0] wt_idx;
    status_t status;
    logic push;
    logic pop;

    assign take       = req.valid && req.ready;
    assign is_holder  = holder_valid_reg && (holder_task_reg == tid_reg);
    assign tid_in_map = {1'b0, tid_reg} < TASK_LIMIT;
    assign wt_in_map  = {1'b0, fifo_rd_data} < TASK_LIMIT;
    assign tid_idx    = tid_reg[MAP_W-1:0];
    assign wt_idx     = fifo_rd_data[MAP_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req.ready    = 1'b0;
        fifo_rd.en   = 1'b0;
        fifo_rd.addr = head_reg;
        map_rd_en    = 1'b0;
        clearing     = 1'b0;
        exec_go      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clearing = 1'b1;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_READ:
            begin
                fifo_rd.en = 1'b1;
                map_rd_en  = 1'b1;
            end
            S_EXEC:
            begin
                exec_go = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Advance the clearing pass over the waiting map
    assign clr_next = clearing ? clr_reg + MAP_W'(1) : clr_reg;

    // Decide the request against the lock state
    always_comb
    begin
        status = ST_NOT_HOLDER;
        push   = 1'b0;
        pop    = 1'b0;
        holder_valid_next = holder_valid_reg;
        holder_task_next  = holder_task_reg;
        nest_next         = nest_reg;
        if (kind_reg == KIND_ACQUIRE)
        begin
            if (is_holder)
            begin
                if (nest_reg == NEST_MAX)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    nest_next = nest_reg + NEST_W'(1);
                    status    = ST_NESTED_GRANT;
                end
            end
            else if (!holder_valid_reg)
            begin
                holder_valid_next = 1'b1;
                holder_task_next  = tid_reg;
                nest_next         = NEST_W'(1);
                status            = ST_GRANTED;
            end
            else if (!tid_in_map || map_hit_reg || used_reg == CNT_FULL)
            begin
                status = ST_QUEUE_ERR;
            end
            else
            begin
                push   = 1'b1;
                status = ST_BLOCKED;
            end
        end
        else
        begin
            if (!is_holder)
            begin
                status = ST_NOT_HOLDER;
            end
            else if (nest_reg > NEST_W'(1))
            begin
                nest_next = nest_reg - NEST_W'(1);
                status    = ST_NESTED_RELEASE;
            end
            else
            begin
                holder_valid_next = 1'b0;
                holder_task_next  = '0;
                nest_next         = '0;
                status            = ST_RELEASED;
                pop               = used_reg != '0;
            end
        end
    end

    // Queue pointers and response
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_wv_next    = out_wv_reg;
        out_wt_next    = out_wt_reg;
        out_nest_next  = out_nest_reg;
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (exec_go)
        begin
            if (push)
            begin
                tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + QPTR_W'(1);
                used_next = used_reg + QCNT_W'(1);
            end
            if (pop)
            begin
                head_next = (head_reg == PTR_LAST) ? '0 : head_reg + QPTR_W'(1);
                used_next = used_reg - QCNT_W'(1);
            end
            out_valid_next  = 1'b1;
            out_status_next = status;
            out_wv_next     = pop;
            out_wt_next     = pop ? fifo_rd_data : '0;
            out_nest_next   = holder_valid_next ? nest_next : '0;
        end
    end

    // Mark a queued task, unmark a woken one, or clear after reset
    always_comb
    begin
        map_wr_en   = 1'b0;
        map_wr_addr = clr_reg;
        map_wr_data = 1'b0;
        if (clearing)
        begin
            map_wr_en = 1'b1;
        end
        else if (exec_go && push)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = tid_idx;
            map_wr_data = 1'b1;
        end
        else if (exec_go && pop && wt_in_map)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = wt_idx;
        end
    end

    // Write the waiting map
    always_ff @(posedge clk)
    begin
        if (map_wr_en)
        begin
            wait_map[map_wr_addr] <= map_wr_data;
        end
    end

    // Registered read of the requester's waiting bit
    always_ff @(posedge clk)
    begin
        if (map_rd_en)
        begin
            map_hit_reg <= wait_map[tid_idx];
        end
    end

    // Push the requester into the queue memory
    assign fifo_wr.en   = exec_go && push;
    assign fifo_wr.addr = tail_reg;
    assign fifo_wr.data = tid_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            holder_valid_reg <= 1'b0;
            holder_task_reg  <= '0;
            nest_reg         <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            used_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            if (exec_go)
            begin
                holder_valid_reg <= holder_valid_next;
                holder_task_reg  <= holder_task_next;
                nest_reg         <= nest_next;
            end
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            used_reg         <= used_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= req.kind;
            tid_reg  <= req.task_id;
        end
        out_status_reg <= out_status_next;
        out_wv_reg     <= out_wv_next;
        out_wt_reg     <= out_wt_next;
        out_nest_reg   <= out_nest_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.woken_valid = out_wv_reg;
    assign rsp.woken_task  = out_wt_reg;
    assign rsp.nest_level  = out_nest_reg;

endmodule

`default_nettype wire

/* sv/recursive_mutex_wait_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// Recursive mutex with a first-in first-out queue of waiting tasks.
// Channels: req (sink) carries kind (0 acquire, 1 release) and task_id;
// rsp (source) carries status, woken_valid, woken_task and nest_level.
// Every request gives exactly one response, in request order.
// Each request reads the head of the wait queue and its own waiting bit
// in the read state, then decides and writes back in the exec state, and
// only then is the next request taken, so no new request is accepted
// while one is still in flight.
// The response sits in an output register, so req.ready rises again while
// a response still waits; if rsp.ready stays low, the next request holds
// in its decide cycle until the response register is emptied.
// Reset (rst_n low, asynchronous) frees the lock, zeroes the nesting
// count and empties the queue at once; the per-task waiting map memory is
// then cleared one entry at a time, all NUM_TASKS (256) of them, with req.ready low.
// The queue memory itself is not cleared, as it is read only where written.
// Errors (not holder, queue full or already waiting, nesting overflow)
// are reported in status and leave the state unchanged.

module recursive_mutex_wait_queue
    import rmwq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmwq_req_if.sink   req,
    rmwq_rsp_if.source rsp
);

    fifo_wr_t          fifo_wr;
    fifo_rd_t          fifo_rd;
    logic [TASK_W-1:0] fifo_rd_data;

    rmwq_fifo_mem u_fifo_mem (
        .clk     (clk),
        .wr      (fifo_wr),
        .rd      (fifo_rd),
        .rd_data (fifo_rd_data)
    );

    rmwq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fifo_wr      (fifo_wr),
        .fifo_rd      (fifo_rd),
        .fifo_rd_data (fifo_rd_data)
    );

    // Only one request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    // A woken task only comes with a final release
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.woken_valid) |-> (rsp.status == ST_RELEASED))
        else $error("woken task without final release");

    // A fresh grant starts at nesting level one
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_GRANTED) |-> (rsp.nest_level == NEST_W'(1)))
        else $error("grant with wrong nesting level");

    // A final release leaves the lock free
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_RELEASED) |-> (rsp.nest_level == '0))
        else $error("release left a nesting level");

endmodule

`default_nettype wire

/* tb/tb_recursive_mutex_wait_queue.sv */
`timescale 1ns / 1ps

module tb_recursive_mutex_wait_queue;
    import rmwq_pkg::*;

    localparam int RUN_LIMIT = 200000;
    localparam int IDLE_PCT  = 14;
    localparam int DIR_ROWS  = 16;

    typedef struct packed {
        status_t           status;
        logic              woken_valid;
        logic [TASK_W-1:0] woken_task;
        logic [NEST_W-1:0] nest_level;
    } lock_resp_t;

    typedef struct packed {
        kind_t             kind;
        logic [TASK_W-1:0] task_id;
        logic              known;
        lock_resp_t        resp;
    } lock_row_t;

    logic clk;
    logic rst_n;

    rmwq_req_if req_ch();
    rmwq_rsp_if rsp_ch();

    recursive_mutex_wait_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Directed requests; rows with known = 0 are checked against the predictor
    lock_row_t dir_rows [DIR_ROWS] = '{
        '{KIND_RELEASE, 8'd5,   1'b1, '{ST_NOT_HOLDER,     1'b0, 8'd0,   8'd0}},
        '{KIND_ACQUIRE, 8'd0,   1'b1, '{ST_GRANTED,        1'b0, 8'd0,   8'd1}},
        '{KIND_ACQUIRE, 8'd0,   1'b1, '{ST_NESTED_GRANT,   1'b0, 8'd0,   8'd2}},
        '{KIND_RELEASE, 8'd255, 1'b1, '{ST_NOT_HOLDER,     1'b0, 8'd0,   8'd2}},
        '{KIND_ACQUIRE, 8'd255, 1'b1, '{ST_BLOCKED,        1'b0, 8'd0,   8'd2}},
        '{KIND_ACQUIRE, 8'd255, 1'b1, '{ST_QUEUE_ERR,      1'b0, 8'd0,   8'd2}},
        '{KIND_ACQUIRE, 8'd170, 1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        '{KIND_RELEASE, 8'd0,   1'b1, '{ST_NESTED_RELEASE, 1'b0, 8'd0,   8'd1}},
        '{KIND_RELEASE, 8'd0,   1'b1, '{ST_RELEASED,       1'b1, 8'd255, 8'd0}},
        // queued task takes the free lock and stays queued
        '{KIND_ACQUIRE, 8'd170, 1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        '{KIND_ACQUIRE, 8'd85,  1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        '{KIND_RELEASE, 8'd170, 1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        '{KIND_ACQUIRE, 8'd85,  1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        '{KIND_RELEASE, 8'd85,  1'b0, '{ST_GRANTED,        1'b0, 8'd0,   8'd0}},
        // release with an empty queue wakes nobody
        '{KIND_ACQUIRE, 8'd51,  1'b1, '{ST_GRANTED,        1'b0, 8'd0,   8'd1}},
        '{KIND_RELEASE, 8'd51,  1'b1, '{ST_RELEASED,       1'b0, 8'd0,   8'd0}}
    };

    // Predicted lock state
    logic                 holder_on;
    logic [TASK_W-1:0]    holder_id;
    logic [NEST_W-1:0]    depth;
    logic [TASK_W-1:0]    waiters [$];
    logic [NUM_TASKS-1:0] is_waiting;

    lock_resp_t        pending_resps [$];
    lock_resp_t        head_resp;
    logic [TASK_W-1:0] rewake [$];
    logic [TASK_W-1:0] pool [$];

    logic calm;
    int   fails;
    int   cycles;
    int   sent;
    int   got;
    int   woken_seen;
    int   st_seen [8];

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Compute the response of one request and advance the lock state
    function automatic lock_resp_t predict_lock(kind_t k, logic [TASK_W-1:0] id);
        lock_resp_t r;
        logic       owner;
        r = '0;
        owner = holder_on && holder_id == id;
        if (k == KIND_ACQUIRE)
        begin
            if (owner)
            begin
                if (depth == NEST_MAX)
                    r.status = ST_OVERFLOW;
                else
                begin
                    depth = depth + 1'b1;
                    r.status = ST_NESTED_GRANT;
                end
            end
            else if (!holder_on)
            begin
                holder_on = 1'b1;
                holder_id = id;
                depth = NEST_W'(1);
                r.status = ST_GRANTED;
            end
            else if (int'(id) >= NUM_TASKS || is_waiting[id] || waiters.size() >= QUEUE_DEPTH)
                r.status = ST_QUEUE_ERR;
            else
            begin
                waiters.push_back(id);
                is_waiting[id] = 1'b1;
                r.status = ST_BLOCKED;
            end
        end
        else
        begin
            if (!owner)
                r.status = ST_NOT_HOLDER;
            else if (depth > 1)
            begin
                depth = depth - 1'b1;
                r.status = ST_NESTED_RELEASE;
            end
            else
            begin
                holder_on = 1'b0;
                holder_id = '0;
                depth = '0;
                r.status = ST_RELEASED;
                if (waiters.size() != 0)
                begin
                    r.woken_task = waiters.pop_front();
                    r.woken_valid = 1'b1;
                    is_waiting[r.woken_task] = 1'b0;
                end
            end
        end
        r.nest_level = holder_on ? depth : '0;
        return r;
    endfunction

    // Drive one request, predict it on acceptance, then maybe idle
    task automatic issue(kind_t k, logic [TASK_W-1:0] id, logic known = 1'b0,
                         lock_resp_t typed_resp = '0);
        lock_resp_t r;
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= k;
        req_ch.task_id <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = predict_lock(k, id);
        if (r.woken_valid)
            rewake.push_back(r.woken_task);
        pending_resps.push_back(known ? typed_resp : r);
        sent++;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Hold the sender until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_resps.size() != 0)
            @(posedge clk);
    endtask

    task automatic new_pool(int count);
        pool.delete();
        repeat (count) pool.push_back(8'($urandom_range(255)));
    endtask

    // Mixed traffic: woken tasks retry, the holder nests and releases, others contend
    task automatic contend(int count);
        int                roll;
        logic [TASK_W-1:0] id;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (rewake.size() != 0 && roll < 40)
                issue(KIND_ACQUIRE, rewake.pop_front());
            else if (holder_on && roll < 70)
                issue(($urandom_range(99) < 55) ? KIND_RELEASE : KIND_ACQUIRE, holder_id);
            else
            begin
                id = pool[$urandom_range(pool.size() - 1)];
                issue((roll < 90) ? KIND_ACQUIRE : KIND_RELEASE, id);
            end
        end
    endtask

    // Free the lock, take it, then queue more tasks than the queue holds
    task automatic flood();
        logic [TASK_W-1:0] base;
        base = 8'($urandom_range(255));
        while (holder_on)
            issue(KIND_RELEASE, holder_id);
        issue(KIND_ACQUIRE, base);
        pool.delete();
        for (int i = 1; i <= QUEUE_DEPTH + 3; i++)
        begin
            pool.push_back(base + 8'(i * 7));
            issue(KIND_ACQUIRE, pool[$]);
        end
        issue(KIND_ACQUIRE, pool[0]);
    endtask

    // Nest one holder up to the count limit, push past it, then unwind
    task automatic deep_nest();
        logic [TASK_W-1:0] owner;
        while (holder_on)
            issue(KIND_RELEASE, holder_id);
        owner = 8'($urandom_range(255));
        issue(KIND_ACQUIRE, owner);
        while (depth != NEST_MAX)
        begin
            if ($urandom_range(99) < 5)
                issue(KIND_ACQUIRE, 8'($urandom_range(255)));
            else
                issue(KIND_ACQUIRE, owner);
        end
        repeat (3) issue(KIND_ACQUIRE, owner);
        while (holder_on && holder_id == owner)
            issue(KIND_RELEASE, owner);
    endtask

    function automatic void cmp_field(string what, logic [7:0] want, logic [7:0] seen);
        if (want !== seen)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
        end
    endfunction

    // Check each response against the oldest expectation and stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got++;
                st_seen[rsp_ch.status]++;
                if (rsp_ch.woken_valid)
                    woken_seen++;
                if (pending_resps.size() == 0)
                begin
                    fails++;
                    $display("%0t: response with none expected, status %0d", $time,
                             rsp_ch.status);
                end
                else
                begin
                    head_resp = pending_resps.pop_front();
                    cmp_field("status", 8'(head_resp.status), 8'(rsp_ch.status));
                    cmp_field("woken_valid", 8'(head_resp.woken_valid),
                              8'(rsp_ch.woken_valid));
                    cmp_field("woken_task", head_resp.woken_task, rsp_ch.woken_task);
                    cmp_field("nest_level", head_resp.nest_level, rsp_ch.nest_level);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ACQUIRE;
        req_ch.task_id = '0;
        rsp_ch.ready = 1'b0;
        holder_on = 1'b0;
        holder_id = '0;
        depth = '0;
        is_waiting = '0;
        calm = 1'b0;
        fails = 0;
        cycles = 0;
        sent = 0;
        got = 0;
        woken_seen = 0;
        foreach (st_seen[i])
            st_seen[i] = 0;

        // Hold reset, then release it at an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
            issue(dir_rows[i].kind, dir_rows[i].task_id, dir_rows[i].known, dir_rows[i].resp);

        // Random traffic in phases
        new_pool(6);
        contend(150);
        drain();
        flood();
        contend(120);
        calm = 1'b1;
        deep_nest();
        calm = 1'b0;
        new_pool(12);
        contend(150);
        flood();
        new_pool(4);
        contend(150);

        // Drop valid and wait for the last responses
        req_ch.valid <= 1'b0;
        while (pending_resps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests, %0d responses, %0d wakeups; grant %0d, nest %0d, block %0d",
                 sent, got, woken_seen, st_seen[ST_GRANTED], st_seen[ST_NESTED_GRANT],
                 st_seen[ST_BLOCKED]);
        $display("release %0d, nested release %0d, not holder %0d, queue error %0d, overflow %0d",
                 st_seen[ST_RELEASED], st_seen[ST_NESTED_RELEASE], st_seen[ST_NOT_HOLDER],
                 st_seen[ST_QUEUE_ERR], st_seen[ST_OVERFLOW]);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
